[hw/rtl/wndd_pkg.sv]
// ----------------------------------------------------------------------------
// wndd_pkg
// Shared widths, depths and register codes for the windowed near-duplicate
// detector.
// ----------------------------------------------------------------------------
package wndd_pkg;

	// Window storage
	localparam int WINDOW_DEPTH = 16;
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

	// Field widths
	localparam int SAMPLE_W = 32;
	localparam int THR_W    = 31;
	localparam int WK_W     = 5;
	localparam int DIFF_W   = SAMPLE_W + 1;

	// Register file
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Register index, taken from paddr[2]
	localparam logic REG_WINDOW_K  = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

endpackage

[hw/rtl/wndd_near.sv]
// ----------------------------------------------------------------------------
// wndd_near
// One compare lane: flags when two signed samples lie within threshold of
// each other, using an exact 33-bit difference.
// ----------------------------------------------------------------------------
module wndd_near
	import wndd_pkg::*;
(
	input  logic signed [SAMPLE_W-1:0] cur,
	input  logic signed [SAMPLE_W-1:0] old,
	input  logic        [THR_W-1:0]    threshold,
	output logic                       hit
);

	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] thr_pos;
	logic signed [DIFF_W-1:0] thr_neg;

	// -threshold <= cur - old <= threshold
	always_comb begin
		diff    = DIFF_W'(cur) - DIFF_W'(old);
		thr_pos = $signed({2'b00, threshold});
		thr_neg = -thr_pos;
		hit     = (diff <= thr_pos) && (diff >= thr_neg);
	end

endmodule

[hw/rtl/windowed_near_duplicate_detector.sv]
// ----------------------------------------------------------------------------
// windowed_near_duplicate_detector
// Flags samples that lie within threshold of one of the previous window_k (at most
// WINDOW_DEPTH) samples of the same sequence, with a sticky per-sequence found flag.
// ----------------------------------------------------------------------------
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-----------------------------------
//  input     | sample_valid / sample_ready   | sample, end_of_sequence
//  result    | result_valid / result_ready   | match_here, found_so_far, sequence_done
//  config    | psel / penable / pwrite       | paddr, pwdata, prdata (pready tied high)
//
// Each item passes the input register, then all window lanes compare in
// parallel into the result register.
// One item per cycle is sustained while the result side does not stall; the
// window shift register updates in the same cycle that an item moves into the
// result register.
// A stall on the result side holds both stages; ready back-pressures through.
// arst_n clears handshake state, fill count, sticky flag and config registers.
// ----------------------------------------------------------------------------
module windowed_near_duplicate_detector
	import wndd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,

	// sample stream
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       end_of_sequence,

	// result stream
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic                       match_here,
	output logic                       found_so_far,
	output logic                       sequence_done,

	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_W-1:0]          paddr,
	input  logic [DATA_W-1:0]          pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready
);

	// Configuration registers
	logic [WK_W-1:0]  window_k_q;
	logic [THR_W-1:0] threshold_q;
	logic             cfg_wr;

	// Input stage
	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       eos_s1;

	// Window state
	logic signed [SAMPLE_W-1:0] hist_q [WINDOW_DEPTH];
	logic [CNT_W-1:0]           fill_q;
	logic                       sticky_q;

	// Result register
	logic out_valid_q;
	logic match_q;
	logic found_q;
	logic done_q;

	// Control
	logic                    out_free;
	logic                    advance;
	logic [WINDOW_DEPTH-1:0] lane_hit;
	logic                    hit;
	logic                    found;

	// ------------------------------------------------------------------
	// Register port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_k_q  <= '0;
			threshold_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WINDOW_K:  window_k_q  <= pwdata[WK_W-1:0];
				REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW_K:  prdata = DATA_W'(window_k_q);
			REG_THRESHOLD: prdata = DATA_W'(threshold_q);
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Handshake: result register frees when empty or being taken
	// ------------------------------------------------------------------
	assign out_free     = !out_valid_q || result_ready;
	assign advance      = valid_s1 && out_free;
	assign sample_ready = !valid_s1 || out_free;

	// Input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
			eos_s1    <= end_of_sequence;
		end
	end

	// ------------------------------------------------------------------
	// Parallel window compare; lane i is live below fill and window_k
	// ------------------------------------------------------------------
	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_lane
		logic near;
		logic live;

		wndd_near u_near (
			.cur       (sample_s1),
			.old       (hist_q[i]),
			.threshold (threshold_q),
			.hit       (near)
		);

		assign live        = (32'(fill_q) > 32'(i)) && (32'(window_k_q) > 32'(i));
		assign lane_hit[i] = near && live;
	end

	assign hit   = |lane_hit;
	assign found = sticky_q || hit;

	// Window history: newest at entry 0, no reset needed
	always_ff @(posedge clk) begin
		if (advance && !eos_s1) begin
			hist_q[0] <= sample_s1;
			for (int i = 1; i < WINDOW_DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	// Fill count and sticky flag, cleared after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			sticky_q <= 1'b0;
		end else if (advance) begin
			if (eos_s1) begin
				fill_q   <= '0;
				sticky_q <= 1'b0;
			end else begin
				sticky_q <= found;
				if (fill_q != CNT_W'(WINDOW_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			match_q <= hit;
			found_q <= found;
			done_q  <= eos_s1;
		end
	end

	assign result_valid  = out_valid_q;
	assign match_here    = match_q;
	assign found_so_far  = found_q;
	assign sequence_done = done_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_DEPTH))
		else $error("fill count beyond window depth");

	a_eos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eos_s1 |=> fill_q == '0 && !sticky_q)
		else $error("window not cleared after end of sequence");

	a_sticky_covers: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && match_here |-> found_so_far)
		else $error("match without sticky found flag");

	a_zero_window: assert property (@(posedge clk) disable iff (!arst_n)
		advance && window_k_q == '0 |=> !match_here)
		else $error("match reported with zero window");

endmodule

[sim/windowed_near_duplicate_detector_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_near_duplicate_detector_tb
// Drives sample sequences through the detector and checks every result
// transfer against an in-bench predictor of the sliding-window compare, the
// sticky found flag and the end-of-sequence clear. Window and threshold are
// reprogrammed over the APB port between phases, mid-sequence as well.
// ----------------------------------------------------------------------------
module windowed_near_duplicate_detector_tb;
	import wndd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1250;

	typedef struct packed {
		logic hit;
		logic found;
		logic done;
	} verdict_t;

	logic                       clk;
	logic                       arst_n;
	logic                       sample_valid;
	logic                       sample_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       end_of_sequence;
	logic                       result_valid;
	logic                       result_ready;
	logic                       match_here;
	logic                       found_so_far;
	logic                       sequence_done;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [ADDR_W-1:0]          paddr;
	logic [DATA_W-1:0]          pwdata;
	logic [DATA_W-1:0]          prdata;
	logic                       pready;

	// predictor state
	logic [WK_W-1:0]            window_k_cfg;
	logic [THR_W-1:0]           threshold_cfg;
	logic signed [SAMPLE_W-1:0] held_samples [WINDOW_DEPTH];
	int                         held_count;
	logic                       sticky_hit;

	verdict_t pending_verdicts [$];
	int       mismatch_count;
	int       cycle_count;
	logic     steady;

	windowed_near_duplicate_detector u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_ready    (sample_ready),
		.sample          (sample),
		.end_of_sequence (end_of_sequence),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.match_here      (match_here),
		.found_so_far    (found_so_far),
		.sequence_done   (sequence_done),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[windowed_near_duplicate_detector] ERROR");
			$finish;
		end
	end

	// expected verdict for one accepted sample; advances the window state
	function automatic verdict_t predict_verdict(logic signed [SAMPLE_W-1:0] value,
			logic last);
		verdict_t v;
		int       span;
		longint   diff;
		span = (window_k_cfg > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(window_k_cfg);
		if (span > held_count)
			span = held_count;
		v.hit = 1'b0;
		for (int i = 0; i < span; i++) begin
			diff = longint'(value) - longint'(held_samples[i]);
			if (diff < 0)
				diff = -diff;
			if (diff <= longint'(threshold_cfg))
				v.hit = 1'b1;
		end
		sticky_hit = sticky_hit | v.hit;
		v.found = sticky_hit;
		v.done = last;
		if (last) begin
			held_count = 0;
			sticky_hit = 1'b0;
		end else begin
			for (int i = WINDOW_DEPTH - 1; i > 0; i--)
				held_samples[i] = held_samples[i - 1];
			held_samples[0] = value;
			if (held_count < WINDOW_DEPTH)
				held_count++;
		end
		return v;
	endfunction

	// result side: random back-pressure and in-order compare
	always @(posedge clk) begin : result_check
		verdict_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (pending_verdicts.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result transfer: match=%0b found=%0b done=%0b",
							match_here, found_so_far, sequence_done);
				end else begin
					want = pending_verdicts.pop_front();
					if ({match_here, found_so_far, sequence_done} !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch match/found/done: expected %0b/%0b/%0b got %0b/%0b/%0b",
								want.hit, want.found, want.done,
								match_here, found_so_far, sequence_done);
					end
				end
			end
			result_ready <= steady || ($urandom_range(99) >= 13);
		end
	end

	// one sample transfer, with a random gap in front
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
		int gap;
		gap = 0;
		while (!steady && $urandom_range(99) < 13)
			gap++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= value;
		end_of_sequence <= last;
		do @(posedge clk); while (!sample_ready);
		pending_verdicts.push_back(predict_verdict(value, last));
	endtask

	// hold off the sender until the pipe is empty
	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// setup and access phases, then the bus goes idle
	task automatic write_register(input logic idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_WINDOW_K)
			window_k_cfg = data[WK_W-1:0];
		else
			threshold_cfg = data[THR_W-1:0];
		@(posedge clk);
	endtask

	// reset values: zero window never matches
	task automatic test_reset_config();
		send_sample(32'sd5, 1'b0);
		send_sample(32'sd5, 1'b1);
	endtask

	// most negative and most positive samples, zero threshold
	task automatic test_value_extremes();
		wait_idle();
		write_register(REG_WINDOW_K, WINDOW_DEPTH);
		write_register(REG_THRESHOLD, 32'd0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h7fff_ffff, 1'b1);
	endtask

	// differences right at and just past the largest threshold
	task automatic test_threshold_edges();
		wait_idle();
		write_register(REG_WINDOW_K, 32'd1);
		write_register(REG_THRESHOLD, 32'h7fff_ffff);
		send_sample(32'sd0, 1'b0);
		send_sample(32'h7fff_ffff, 1'b0);
		send_sample(-32'sd1, 1'b0);
		send_sample(32'h8000_0000, 1'b1);
	endtask

	// full history, then window widened past depth in mid-sequence
	task automatic test_window_depth();
		wait_idle();
		write_register(REG_WINDOW_K, WINDOW_DEPTH - 1);
		write_register(REG_THRESHOLD, 32'd0);
		send_sample(32'h1234_5678, 1'b0);
		repeat (WINDOW_DEPTH - 1) send_sample(32'hedcb_a987, 1'b0);
		wait_idle();
		write_register(REG_WINDOW_K, 32'd31);
		send_sample(32'h1234_5678, 1'b1);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(
			logic signed [SAMPLE_W-1:0] base);
		case ($urandom_range(9))
			0: return $urandom;
			1: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return base + $urandom_range(64) - 32;
		endcase
	endfunction

	task automatic pick_config();
		logic [DATA_W-1:0] k;
		logic [DATA_W-1:0] t;
		case ($urandom_range(4))
			0: k = 0;
			1: k = 1;
			2: k = WINDOW_DEPTH;
			3: k = $urandom_range(31, WINDOW_DEPTH + 1);
			default: k = $urandom_range(WINDOW_DEPTH);
		endcase
		case ($urandom_range(4))
			0: t = 0;
			1: t = $urandom_range(40);
			2: t = $urandom_range(1000);
			3: t = 32'h7fff_ffff;
			default: t = $urandom >> 1;
		endcase
		write_register(REG_WINDOW_K, k);
		write_register(REG_THRESHOLD, t);
	endtask

	// clustered sequences of random length, config changed every phase
	task automatic test_random_stream();
		int                         seq_left;
		logic signed [SAMPLE_W-1:0] base;
		seq_left = 0;
		base = '0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 125 == 0) begin
				wait_idle();
				pick_config();
			end else if (n == 700) begin
				wait_idle();
			end
			steady = (n >= 400 && n < 600);
			if (seq_left == 0) begin
				seq_left = ($urandom_range(9) == 0) ? $urandom_range(48, WINDOW_DEPTH + 1)
					: $urandom_range(12, 1);
				base = $urandom;
			end
			send_sample(pick_sample(base), seq_left == 1);
			seq_left--;
		end
		steady = 1'b0;
	endtask

	initial begin
		window_k_cfg = '0;
		threshold_cfg = '0;
		held_count = 0;
		sticky_hit = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		steady = 1'b0;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		end_of_sequence <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_value_extremes();
		test_threshold_edges();
		test_window_depth();
		test_random_stream();

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_verdicts.size() == 0)
			$display("[windowed_near_duplicate_detector] OK");
		else
			$display("[windowed_near_duplicate_detector] ERROR");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/wndd_pkg.sv
hw/rtl/wndd_near.sv
hw/rtl/windowed_near_duplicate_detector.sv
sim/windowed_near_duplicate_detector_tb.sv
